[src/tbts_pkg.sv]
package tbts_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] WORD_STEP  = 32'd4;
  localparam logic [31:0] EMPTY_STEP = 32'h40;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_STM  = 2'd2,
    KIND_LDM  = 2'd3
  } kind_t;

  // decoded instruction handed from front to back
  typedef struct packed {
    logic [8:0]  mask;      // bits 7..0 low regs, bit 8 lr/pc slot
    logic        descend;
    logic        wr;
    logic        is_stm;
    logic [2:0]  rb;
    logic [3:0]  high_reg;
    logic [31:0] addr;
    logic [3:0]  wbr;
    logic [31:0] wbv;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/tbts_if.sv]
interface tbts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] opcode;
  logic [31:0] base_value;
  logic [31:0] sp_value;
  logic [31:0] pc_value;

  modport source (output valid, kind, opcode, base_value, sp_value, pc_value, input ready);
  modport sink   (input valid, kind, opcode, base_value, sp_value, pc_value, output ready);
endinterface

interface tbts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        is_write;
  logic [3:0]  reg_index;
  logic        use_new_base;
  logic        sequential;
  logic        writeback_now;
  logic [3:0]  wb_reg;
  logic [31:0] wb_value;
  logic        last;

  modport source (output valid, address, is_write, reg_index, use_new_base, sequential,
                  writeback_now, wb_reg, wb_value, last, input ready);
  modport sink   (input valid, address, is_write, reg_index, use_new_base, sequential,
                  writeback_now, wb_reg, wb_value, last, output ready);
endinterface

[src/tbts_front.sv]
module tbts_front (
  tbts_in_if.sink              in_ch,
  input  tbts_pkg::queue_stat_t stat_i,
  output tbts_pkg::desc_t       desc_o,
  output logic                  push_o
);

  logic        push_pop;
  logic        empty;
  logic [8:0]  mask;
  logic [3:0]  cnt;
  logic [31:0] delta;

  assign in_ch.ready = !stat_i.full;
  assign push_o      = in_ch.valid && !stat_i.full;

  always_comb begin
    push_pop = (in_ch.kind == tbts_pkg::KIND_PUSH) || (in_ch.kind == tbts_pkg::KIND_POP);
    empty    = push_pop ? (in_ch.opcode[8:0] == 9'd0) : (in_ch.opcode[7:0] == 8'd0);
    if (empty) begin
      mask = 9'h100;
    end else if (push_pop) begin
      mask = in_ch.opcode[8:0];
    end else begin
      mask = {1'b0, in_ch.opcode[7:0]};
    end
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + 4'(mask[i]);
    end
    delta = empty ? tbts_pkg::EMPTY_STEP : {26'd0, cnt, 2'b00};

    desc_o.mask     = mask;
    desc_o.descend  = (in_ch.kind == tbts_pkg::KIND_PUSH);
    desc_o.is_stm   = (in_ch.kind == tbts_pkg::KIND_STM);
    desc_o.rb       = in_ch.opcode[10:8];
    desc_o.high_reg = ((in_ch.kind == tbts_pkg::KIND_PUSH) && !empty) ?
                      tbts_pkg::REG_LR : tbts_pkg::REG_PC;
    case (in_ch.kind)
      tbts_pkg::KIND_PUSH: begin
        desc_o.wr   = 1'b1;
        desc_o.wbr  = tbts_pkg::REG_SP;
        desc_o.wbv  = in_ch.sp_value - delta;
        desc_o.addr = empty ? (in_ch.sp_value - tbts_pkg::EMPTY_STEP)
                            : (in_ch.sp_value - tbts_pkg::WORD_STEP);
      end
      tbts_pkg::KIND_POP: begin
        desc_o.wr   = 1'b0;
        desc_o.wbr  = tbts_pkg::REG_SP;
        desc_o.wbv  = in_ch.sp_value + delta;
        desc_o.addr = in_ch.sp_value;
      end
      tbts_pkg::KIND_STM: begin
        desc_o.wr   = 1'b1;
        desc_o.wbr  = {1'b0, in_ch.opcode[10:8]};
        desc_o.wbv  = in_ch.base_value + delta;
        desc_o.addr = in_ch.base_value;
      end
      default: begin
        desc_o.wr   = 1'b0;
        desc_o.wbr  = {1'b0, in_ch.opcode[10:8]};
        desc_o.wbv  = in_ch.base_value + delta;
        desc_o.addr = in_ch.base_value;
      end
    endcase
  end

endmodule

[src/tbts_queue.sv]
module tbts_queue #(
  parameter int DEPTH = tbts_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  tbts_pkg::desc_t        desc_i,
  input  logic                   pop_i,
  output tbts_pkg::desc_t        desc_o,
  output tbts_pkg::queue_stat_t  stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tbts_pkg::desc_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign stat_o.full  = (count_r == CNT_W'(DEPTH));
  assign stat_o.empty = (count_r == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign desc_o       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= desc_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/tbts_back.sv]
module tbts_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbts_pkg::desc_t       desc_i,
  input  tbts_pkg::queue_stat_t stat_i,
  output logic                  pop_o,
  tbts_out_if.source            out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t      state_r;
  logic [8:0]  mask_r;
  logic [31:0] addr_r;
  logic        first_r;
  logic        descend_r;
  logic        wr_r;
  logic        is_stm_r;
  logic [2:0]  rb_r;
  logic [3:0]  high_reg_r;
  logic [3:0]  wbr_r;
  logic [31:0] wbv_r;

  logic        out_valid_r;
  logic [31:0] o_addr_r;
  logic        o_wr_r;
  logic [3:0]  o_reg_r;
  logic        o_newb_r;
  logic        o_seq_r;
  logic        o_wbnow_r;
  logic [3:0]  o_wbr_r;
  logic [31:0] o_wbv_r;
  logic        o_last_r;

  logic [8:0]  sel;
  logic [3:0]  reg_sel;
  logic        found;
  logic [8:0]  mask_nxt;
  logic        emit;

  assign pop_o = (state_r == ST_IDLE) && !stat_i.empty;
  assign emit  = (state_r == ST_RUN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    sel     = '0;
    reg_sel = '0;
    found   = 1'b0;
    if (descend_r) begin
      if (mask_r[8]) begin
        sel     = 9'h100;
        reg_sel = high_reg_r;
      end else begin
        for (int i = 7; i >= 0; i--) begin
          if (mask_r[i] && !found) begin
            found   = 1'b1;
            sel     = 9'd1 << i;
            reg_sel = 4'(i);
          end
        end
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (mask_r[i] && !found) begin
          found   = 1'b1;
          sel     = 9'd1 << i;
          reg_sel = 4'(i);
        end
      end
      if (!found && mask_r[8]) begin
        sel     = 9'h100;
        reg_sel = high_reg_r;
      end
    end
    mask_nxt = mask_r & ~sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!stat_i.empty) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && (mask_nxt == '0)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      mask_r     <= desc_i.mask;
      addr_r     <= desc_i.addr;
      first_r    <= 1'b1;
      descend_r  <= desc_i.descend;
      wr_r       <= desc_i.wr;
      is_stm_r   <= desc_i.is_stm;
      rb_r       <= desc_i.rb;
      high_reg_r <= desc_i.high_reg;
      wbr_r      <= desc_i.wbr;
      wbv_r      <= desc_i.wbv;
    end else if (emit) begin
      mask_r  <= mask_nxt;
      addr_r  <= descend_r ? (addr_r - tbts_pkg::WORD_STEP) : (addr_r + tbts_pkg::WORD_STEP);
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_addr_r  <= addr_r;
      o_wr_r    <= wr_r;
      o_reg_r   <= reg_sel;
      o_newb_r  <= is_stm_r && !first_r && (reg_sel == {1'b0, rb_r});
      o_seq_r   <= !first_r;
      o_wbnow_r <= first_r;
      o_wbr_r   <= wbr_r;
      o_wbv_r   <= wbv_r;
      o_last_r  <= (mask_nxt == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.address       = o_addr_r;
  assign out_ch.is_write      = o_wr_r;
  assign out_ch.reg_index     = o_reg_r;
  assign out_ch.use_new_base  = o_newb_r;
  assign out_ch.sequential    = o_seq_r;
  assign out_ch.writeback_now = o_wbnow_r;
  assign out_ch.wb_reg        = o_wbr_r;
  assign out_ch.wb_value      = o_wbv_r;
  assign out_ch.last          = o_last_r;

endmodule

[src/thumb_block_transfer_sequencer_top.sv]
// Path: the front decodes an accepted instruction into the queue; the back end
//   loads the head descriptor in its idle state, then emits registered access
//   beats, one per cycle unless the output stalls, 1 to 9 per instruction.
// The decode queue lets the front take up to QUEUE_DEPTH instructions ahead.
// Reset: synchronous active-low rst_n clears the queue, sequencer and output valid.
module thumb_block_transfer_sequencer_top #(
  parameter int QUEUE_DEPTH = tbts_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  tbts_in_if.sink     in_ch,
  tbts_out_if.source  out_ch
);

  tbts_pkg::desc_t       front_desc;
  tbts_pkg::desc_t       head_desc;
  tbts_pkg::queue_stat_t q_stat;
  logic                  q_push;
  logic                  q_pop;

  tbts_front u_front (
    .in_ch  (in_ch),
    .stat_i (q_stat),
    .desc_o (front_desc),
    .push_o (q_push)
  );

  tbts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .desc_i (front_desc),
    .pop_i  (q_pop),
    .desc_o (head_desc),
    .stat_o (q_stat)
  );

  tbts_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .desc_i (head_desc),
    .stat_i (q_stat),
    .pop_o  (q_pop),
    .out_ch (out_ch)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_stat.empty) |=> !q_stat.empty)
    else $error("accepted instruction lost from queue");

  a_first_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.writeback_now != out_ch.sequential))
    else $error("writeback and sequential flags inconsistent");

  a_new_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.use_new_base) |-> (out_ch.is_write && out_ch.sequential))
    else $error("new base flagged on non-store or first beat");

endmodule

[sim/thumb_block_transfer_sequencer_top_tb.sv]
`timescale 1ns / 100ps

module thumb_block_transfer_sequencer_top_tb;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT     = 38;

  typedef struct packed {
    logic [31:0] address;
    logic        is_write;
    logic [3:0]  reg_index;
    logic        use_new_base;
    logic        sequential;
    logic        writeback_now;
    logic [3:0]  wb_reg;
    logic [31:0] wb_value;
    logic        last;
  } access_t;

  logic clk;
  logic rst_n;

  tbts_in_if  in_if ();
  tbts_out_if out_if ();

  thumb_block_transfer_sequencer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  access_t pending_accesses[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;
  bit      rx_hold = 1'b0;
  event    hold_ev;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sink side: random idling plus a long hold-off on request
  always @(posedge clk) begin
    out_if.ready <= rst_n && !rx_hold && !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
  end

  always begin
    @(hold_ev);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  // expected access sequence for one instruction
  function automatic void predict_accesses(tbts_pkg::kind_t kind, logic [15:0] opcode,
                                           logic [31:0] base, logic [31:0] sp);
    logic [3:0]  regs[9];
    int          n;
    logic [7:0]  list;
    logic        rbit;
    logic [2:0]  rb;
    logic [31:0] addr;
    logic [31:0] step;
    logic [31:0] wbv;
    logic [3:0]  wbr;
    logic        wr;
    access_t     a;
    n    = 0;
    list = opcode[7:0];
    rbit = opcode[8];
    rb   = opcode[10:8];
    step = tbts_pkg::WORD_STEP;
    case (kind)
      tbts_pkg::KIND_PUSH: begin
        wr  = 1'b1;
        wbr = tbts_pkg::REG_SP;
        if (list == 8'd0 && !rbit) begin
          regs[n] = tbts_pkg::REG_PC;
          n++;
          addr = sp - tbts_pkg::EMPTY_STEP;
          wbv  = addr;
        end else begin
          if (rbit) begin
            regs[n] = tbts_pkg::REG_LR;
            n++;
          end
          for (int i = 7; i >= 0; i--) begin
            if (list[i]) begin
              regs[n] = 4'(i);
              n++;
            end
          end
          addr = sp - tbts_pkg::WORD_STEP;
          step = -tbts_pkg::WORD_STEP;
          wbv  = sp - tbts_pkg::WORD_STEP * 32'(n);
        end
      end
      tbts_pkg::KIND_POP: begin
        wr   = 1'b0;
        wbr  = tbts_pkg::REG_SP;
        addr = sp;
        if (list == 8'd0 && !rbit) begin
          regs[n] = tbts_pkg::REG_PC;
          n++;
          wbv = sp + tbts_pkg::EMPTY_STEP;
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (list[i]) begin
              regs[n] = 4'(i);
              n++;
            end
          end
          if (rbit) begin
            regs[n] = tbts_pkg::REG_PC;
            n++;
          end
          wbv = sp + tbts_pkg::WORD_STEP * 32'(n);
        end
      end
      default: begin
        wr   = (kind == tbts_pkg::KIND_STM);
        wbr  = {1'b0, rb};
        addr = base;
        if (list == 8'd0) begin
          regs[n] = tbts_pkg::REG_PC;
          n++;
          wbv = base + tbts_pkg::EMPTY_STEP;
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (list[i]) begin
              regs[n] = 4'(i);
              n++;
            end
          end
          wbv = base + tbts_pkg::WORD_STEP * 32'(n);
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      a.address       = addr;
      a.is_write      = wr;
      a.reg_index     = regs[k];
      a.use_new_base  = (kind == tbts_pkg::KIND_STM) && (k != 0) && (regs[k] == {1'b0, rb})
                        && (list != 8'd0);
      a.sequential    = (k != 0);
      a.writeback_now = (k == 0);
      a.wb_reg        = wbr;
      a.wb_value      = wbv;
      a.last          = (k == n - 1);
      pending_accesses.push_back(a);
      addr = addr + step;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    access_t got;
    access_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.address, out_if.is_write, out_if.reg_index, out_if.use_new_base,
              out_if.sequential, out_if.writeback_now, out_if.wb_reg, out_if.wb_value,
              out_if.last};
      if (pending_accesses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: expected none, actual addr %h reg %0d",
                 $time, got.address, got.reg_index);
      end else begin
        want = pending_accesses.pop_front();
        check_field("address", want.address, got.address);
        check_field("is_write", 32'(want.is_write), 32'(got.is_write));
        check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
        check_field("use_new_base", 32'(want.use_new_base), 32'(got.use_new_base));
        check_field("sequential", 32'(want.sequential), 32'(got.sequential));
        check_field("writeback_now", 32'(want.writeback_now), 32'(got.writeback_now));
        check_field("wb_reg", 32'(want.wb_reg), 32'(got.wb_reg));
        check_field("wb_value", want.wb_value, got.wb_value);
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // call at a rising edge; returns at the edge that takes the beat
  task automatic send_instr(tbts_pkg::kind_t kind, logic [15:0] opcode, logic [31:0] base,
                            logic [31:0] sp, logic [31:0] pc);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.opcode     <= opcode;
    in_if.base_value <= base;
    in_if.sp_value   <= sp;
    in_if.pc_value   <= pc;
    do @(posedge clk); while (!in_if.ready);
    predict_accesses(kind, opcode, base, sp);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(63));
      3:       return 32'hFFFF_FFC0 + 32'($urandom_range(63));
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic send_random_instr();
    logic [15:0] op;
    int          r;
    op = 16'($urandom);
    r  = $urandom_range(9);
    if (r < 2) op[7:0] = 8'd0;
    if (r == 0) op[8] = 1'b0;
    send_instr(tbts_pkg::kind_t'($urandom_range(3)), op, pick_word(), pick_word(),
               pick_word());
  endtask

  task automatic wait_all_done();
    in_if.valid <= 1'b0;
    while (pending_accesses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    // empty lists: pc transferred, base or sp moves by 0x40
    send_instr(tbts_pkg::KIND_PUSH, 16'h0000, 32'h0, 32'h0000_1000, 32'h0);
    send_instr(tbts_pkg::KIND_POP,  16'hFE00, 32'h0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_instr(tbts_pkg::KIND_STM,  16'h0700, 32'hFFFF_FFE0, 32'h0, 32'h0);
    send_instr(tbts_pkg::KIND_LDM,  16'hF800, 32'h0000_0000, 32'h0, 32'h8000_0000);
    // push / pop lists: full, lr / pc only, and single registers
    send_instr(tbts_pkg::KIND_PUSH, 16'h01FF, 32'h0, 32'h0000_0000, 32'h0);
    send_instr(tbts_pkg::KIND_POP,  16'h01FF, 32'h0, 32'hFFFF_FFFC, 32'h0);
    send_instr(tbts_pkg::KIND_PUSH, 16'h0100, 32'h0, 32'h0000_2000, 32'h0);
    send_instr(tbts_pkg::KIND_POP,  16'h0100, 32'h0, 32'h0000_2000, 32'h0);
    send_instr(tbts_pkg::KIND_PUSH, 16'hFE80, 32'h0, 32'h0000_0004, 32'h0);
    send_instr(tbts_pkg::KIND_POP,  16'h0001, 32'h0, 32'hFFFF_FFFF, 32'h0);
    // store multiple: base first in list stores old base, later stores new base
    send_instr(tbts_pkg::KIND_STM,  16'h00FF, 32'h1000_0000, 32'h0, 32'h0);
    send_instr(tbts_pkg::KIND_STM,  16'h05FF, 32'hFFFF_FFF8, 32'h0, 32'h0);
    send_instr(tbts_pkg::KIND_STM,  16'h0721, 32'h0000_0100, 32'h0, 32'h0);
    send_instr(tbts_pkg::KIND_STM,  16'hFF80, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(tbts_pkg::KIND_STM,  16'h0404, 32'h0000_0040, 32'h0, 32'h0);
    // load multiple with base in list
    send_instr(tbts_pkg::KIND_LDM,  16'h0308, 32'h0000_0200, 32'h0, 32'h0);
    send_instr(tbts_pkg::KIND_LDM,  16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_instr(tbts_pkg::KIND_LDM,  16'h0201, 32'hABCD_EF00, 32'h0, 32'h0);
    wait_all_done();
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (70) send_random_instr();
    wait_all_done();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    -> hold_ev;
    repeat (20) send_random_instr();
    tx_idle_on = 1'b1;
    wait_all_done();
  endtask

  task automatic test_random();
    repeat (140) send_random_instr();
    wait_all_done();
    repeat (150) send_random_instr();
    wait_all_done();
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.kind       <= tbts_pkg::KIND_PUSH;
    in_if.opcode     <= 16'h0;
    in_if.base_value <= 32'h0;
    in_if.sp_value   <= 32'h0;
    in_if.pc_value   <= 32'h0;
    rst_n            <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_no_idle();
    test_backpressure();
    test_random();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
